/* design/ebfe_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped byte frame encoder package
// Shared types, constants and helpers for the framer's front end, job queue
// and byte sequencer.
// ----------------------------------------------------------------------------
package ebfe_pkg;

    // Largest allowed length byte (payload length plus three header bytes).
    localparam int MAX_FRAME = 100;

    // Line markers.
    localparam logic [7:0] MARK_START = 8'h7E;
    localparam logic [7:0] MARK_END   = 8'h7F;
    localparam logic [7:0] MARK_ESC   = 8'h7D;
    localparam logic [7:0] ESC_FLIP   = 8'h20;

    // Header bytes counted into the length byte.
    localparam logic [7:0] HDR_BYTES  = 8'd3;

    // Input command codes.
    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    // Job queue between front end and sequencer; depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Index of the last byte of each job kind.
    localparam logic [1:0] HDR_LAST_IDX  = 2'd2;
    localparam logic [1:0] DATA_LAST_IDX = 2'd0;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic [7:0] type_byte;
        logic [7:0] peer_index;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } t_in_item;

    // One output beat.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_end;
        logic       dropped;
        logic       last_of_run;
    } t_out_item;

    // Kind of work handed from the front end to the sequencer.
    typedef enum logic [1:0] {
        JOB_DROP,
        JOB_HEADER,
        JOB_DATA
    } t_job_kind;

    // One queued job: up to three escapable bytes, optionally closed by 0x7F.
    typedef struct packed {
        t_job_kind       kind;
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            add_end;
    } t_job;

    // Write side of the job queue.
    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    // Read side of the job queue.
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BYTE,
        PH_ESC2,
        PH_END,
        PH_DROP
    } t_phase;

    // True for bytes that must be escaped on the line.
    function automatic logic is_special(input logic [7:0] b);
        return (b == MARK_START) || (b == MARK_END) || (b == MARK_ESC);
    endfunction

endpackage

/* design/ebfe_front.sv */
// ----------------------------------------------------------------------------
// Escaped byte frame encoder front end
// Accepts input beats, tracks the open frame or discard run, and turns each
// beat that produces output into one job for the queue.
// ----------------------------------------------------------------------------
module ebfe_front import ebfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_full,
    output t_push    o_push
);

    logic [7:0] r_bytes_left, n_bytes_left;
    logic       r_in_frame,   n_in_frame;
    logic       r_discarding, n_discarding;

    logic       accept;
    logic [8:0] frame_len;
    logic       oversize;
    logic       last_byte;

    // A beat is taken whenever the queue has room for its job.
    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign frame_len = {1'b0, i_item.payload_len} + {1'b0, HDR_BYTES};
    assign oversize  = frame_len > 9'(MAX_FRAME);
    assign last_byte = (r_bytes_left == 8'd1);

    // Classify the beat, build its job and update the frame state.
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_in_frame   = r_in_frame;
        n_discarding = r_discarding;
        o_push       = '0;
        o_push.job.kind = JOB_DROP;

        if (accept) begin
            if (i_item.cmd == CMD_HEADER) begin
                // A header always starts afresh.
                n_in_frame   = 1'b0;
                n_discarding = 1'b0;
                n_bytes_left = '0;
                o_push.push  = 1'b1;
                if (oversize) begin
                    o_push.job.kind = JOB_DROP;
                    if (i_item.payload_len != 8'd0) begin
                        n_discarding = 1'b1;
                        n_bytes_left = i_item.payload_len;
                    end
                end else begin
                    o_push.job.kind     = JOB_HEADER;
                    o_push.job.bytes[0] = frame_len[7:0];
                    o_push.job.bytes[1] = i_item.type_byte;
                    o_push.job.bytes[2] = i_item.peer_index;
                    o_push.job.last_idx = HDR_LAST_IDX;
                    o_push.job.add_end  = (i_item.payload_len == 8'd0);
                    if (i_item.payload_len != 8'd0) begin
                        n_in_frame   = 1'b1;
                        n_bytes_left = i_item.payload_len;
                    end
                end
            end else if (r_discarding) begin
                // Payload of a dropped frame is swallowed.
                n_bytes_left = r_bytes_left - 8'd1;
                if (last_byte) begin
                    n_discarding = 1'b0;
                end
            end else if (r_in_frame) begin
                o_push.push         = 1'b1;
                o_push.job.kind     = JOB_DATA;
                o_push.job.bytes[0] = i_item.data_byte;
                o_push.job.last_idx = DATA_LAST_IDX;
                o_push.job.add_end  = last_byte;
                n_bytes_left        = r_bytes_left - 8'd1;
                if (last_byte) begin
                    n_in_frame = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_in_frame   <= 1'b0;
            r_discarding <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_in_frame   <= n_in_frame;
            r_discarding <= n_discarding;
        end
    end

endmodule

/* design/ebfe_queue.sv */
// ----------------------------------------------------------------------------
// Escaped byte frame encoder job queue
// Small first-in first-out queue of jobs between front end and sequencer.
// ----------------------------------------------------------------------------
module ebfe_queue import ebfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_full       = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    assign do_push = i_push.push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Pointer and fill count update; pointers wrap at the power-of-two depth.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

endmodule

/* design/ebfe_back.sv */
// ----------------------------------------------------------------------------
// Escaped byte frame encoder sequencer
// Takes jobs from the queue and emits their line bytes one beat at a time,
// inserting escapes and the end marker, through an output register.
// ----------------------------------------------------------------------------
module ebfe_back import ebfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    t_phase     r_phase, n_phase;
    t_job       r_job,   n_job;
    logic [1:0] r_idx,   n_idx;

    logic       r_out_valid, n_out_valid;
    t_out_item  r_out,       n_out;

    logic       advance;
    logic [7:0] cur_byte;
    logic       cur_special;
    logic       at_last;
    t_out_item  res;
    logic       job_done;

    // The sequencer moves whenever the output register is free or draining.
    assign advance     = !r_out_valid || i_ready;
    assign cur_byte    = r_job.bytes[r_idx];
    assign cur_special = is_special(cur_byte);
    assign at_last     = (r_idx == r_job.last_idx);

    // Beat produced in the current phase, and whether it closes the job.
    always_comb begin
        res      = '0;
        job_done = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                job_done = 1'b1;
            end
            PH_START: begin
                res.line_byte = MARK_START;
            end
            PH_BYTE: begin
                if (cur_special) begin
                    res.line_byte = MARK_ESC;
                end else begin
                    res.line_byte   = cur_byte;
                    res.last_of_run = at_last && !r_job.add_end;
                    job_done        = at_last && !r_job.add_end;
                end
            end
            PH_ESC2: begin
                res.line_byte   = cur_byte ^ ESC_FLIP;
                res.last_of_run = at_last && !r_job.add_end;
                job_done        = at_last && !r_job.add_end;
            end
            PH_END: begin
                res.line_byte   = MARK_END;
                res.frame_end   = 1'b1;
                res.last_of_run = 1'b1;
                job_done        = 1'b1;
            end
            PH_DROP: begin
                res.dropped     = 1'b1;
                res.last_of_run = 1'b1;
                job_done        = 1'b1;
            end
            default: begin
                job_done = 1'b1;
            end
        endcase
    end

    // Next phase, byte index and job; a finished job hands over to the next.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_job   = r_job;
        o_pop   = 1'b0;
        if ((r_phase == PH_IDLE) || (advance && job_done)) begin
            n_idx = '0;
            if (i_head.valid) begin
                o_pop = 1'b1;
                n_job = i_head.job;
                case (i_head.job.kind)
                    JOB_DROP:   n_phase = PH_DROP;
                    JOB_HEADER: n_phase = PH_START;
                    JOB_DATA:   n_phase = PH_BYTE;
                    default:    n_phase = PH_DROP;
                endcase
            end else begin
                n_phase = PH_IDLE;
            end
        end else if (advance) begin
            case (r_phase)
                PH_START: begin
                    n_phase = PH_BYTE;
                end
                PH_BYTE: begin
                    if (cur_special) begin
                        n_phase = PH_ESC2;
                    end else if (!at_last) begin
                        n_idx = r_idx + 2'd1;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_ESC2: begin
                    if (!at_last) begin
                        n_idx   = r_idx + 2'd1;
                        n_phase = PH_BYTE;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Output register load and drain.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (advance && (r_phase != PH_IDLE)) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* design/escaped_byte_frame_encoder.sv */
// ----------------------------------------------------------------------------
// Escaped byte frame encoder
// Packs header and payload beats into byte-stuffed frames for a serial line.
// ----------------------------------------------------------------------------
// A header beat opens a frame (0x7E, length, type, peer index) and the
// announced number of payload beats follow; the end marker 0x7F closes it.
// Bytes equal to 0x7E, 0x7F or 0x7D leave as 0x7D and the byte XOR 0x20.
// Oversize frames give one beat with dropped set and their payload is
// swallowed. The input side takes one beat per cycle while the four-entry
// job queue has room. The output side sends one line byte per cycle while
// i_ready is high: a header gives 0x7E and three bytes, each escaped as
// needed, a payload beat gives its byte, escaped as needed, and 0x7F follows
// the last byte of a frame, so the sequencer's output sets the input rate.
// ----------------------------------------------------------------------------
module escaped_byte_frame_encoder import ebfe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    t_push   push;
    logic    full;
    t_q_head head;
    logic    pop;

    // Classify incoming beats into jobs.
    ebfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push)
    );

    // Decouple front end from the line sequencer.
    ebfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Emit line bytes.
    ebfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule
